@@ src/cte_pkg.sv @@
// Package for the copy text field escaper: item types, character constants
// and the escape encoder used by the emitter.
// Depends on nothing.
`default_nettype none

package cte_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TILDE     = 8'h7E;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_UPPER_N   = 8'h4E;
    localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
    localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_V   = 8'h76;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;

    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_NULL = 1'b1;

    localparam int MAX_RUN = 4;
    localparam int IDX_W   = $clog2(MAX_RUN);

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } cte_item_t;

    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [IDX_W-1:0]        last_idx;
    } cte_seq_t;

    typedef struct packed {
        logic      valid;
        cte_item_t item;
    } cte_stage_t;

    function automatic logic [7:0] cte_letter(input logic [7:0] c);
        logic [7:0] e;
        unique case (c)
            CODE_BS:        e = CHAR_LOWER_B;
            CODE_TAB:       e = CHAR_LOWER_T;
            CODE_LF:        e = CHAR_LOWER_N;
            CODE_VT:        e = CHAR_LOWER_V;
            CODE_FF:        e = CHAR_LOWER_F;
            CODE_CR:        e = CHAR_LOWER_R;
            CHAR_BACKSLASH: e = CHAR_BACKSLASH;
            default:        e = 8'd0;
        endcase
        return e;
    endfunction

    function automatic cte_seq_t cte_encode(input cte_item_t it);
        cte_seq_t   s;
        logic [7:0] e;
        logic [7:0] c;
        s = '0;
        c = it.data_byte;
        e = cte_letter(c);
        if (it.kind == KIND_NULL)
        begin
            s.bytes[0] = CHAR_BACKSLASH;
            s.bytes[1] = CHAR_UPPER_N;
            s.last_idx = IDX_W'(1);
        end
        else if (e != 8'd0)
        begin
            s.bytes[0] = CHAR_BACKSLASH;
            s.bytes[1] = e;
            s.last_idx = IDX_W'(1);
        end
        else if (c < CHAR_SPACE || c > CHAR_TILDE)
        begin
            s.bytes[0] = CHAR_BACKSLASH;
            s.bytes[1] = CHAR_ZERO + {6'd0, c[7:6]};
            s.bytes[2] = CHAR_ZERO + {5'd0, c[5:3]};
            s.bytes[3] = CHAR_ZERO + {5'd0, c[2:0]};
            s.last_idx = IDX_W'(3);
        end
        else
        begin
            s.bytes[0] = c;
            s.last_idx = IDX_W'(0);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ src/cte_if.sv @@
// Valid/ready channel interfaces for field items and escaped text items.
// Depends on nothing.
`default_nettype none

interface cte_field_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface cte_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/cte_in_stage.sv @@
// Input register for field items, refilled in the cycle the emitter takes it.
// Depends on cte_pkg and cte_field_if.
`default_nettype none

module cte_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cte_field_if.sink              field,
    input  wire logic              take,
    output cte_pkg::cte_stage_t    stage
);
    import cte_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cte_item_t item_reg;
    logic      accept;

    assign field.ready = !valid_reg || take;
    assign accept      = field.valid && field.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind      <= field.kind;
            item_reg.data_byte <= field.data_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

@@ src/cte_emit.sv @@
// Encodes the held field item and sends its escaped bytes one per cycle while text.ready is high.
// Depends on cte_pkg and cte_text_if.
`default_nettype none

module cte_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cte_pkg::cte_stage_t stage,
    output logic                   take,
    cte_text_if.source             text
);
    import cte_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    cte_seq_t         seq_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             is_last;
    logic             free;

    assign is_last = (idx_reg == seq_reg.last_idx);
    assign free    = !valid_reg || (text.ready && is_last);
    assign take    = free && stage.valid;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (free)
        begin
            valid_next = stage.valid;
            idx_next   = '0;
        end
        else if (text.ready)
            idx_next = idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            seq_reg <= cte_encode(stage.item);
    end

    assign text.valid       = valid_reg;
    assign text.out_byte    = seq_reg.bytes[idx_reg];
    assign text.last_of_run = is_last;

endmodule

`default_nettype wire

@@ src/copy_text_field_escaper.sv @@
// Top level of the copy text field escaper: input register plus byte emitter.
// Depends on cte_pkg, cte_if, cte_in_stage and cte_emit.
//
// Usage:
//   field channel: one item per field byte (kind = data) or per null field
//   (kind = null, data_byte ignored). Empty fields send no item.
//   text channel: one item per escaped output byte; last_of_run marks the
//   final byte produced for a field item.
// Path: an accepted field item passes the input register, then the sequence
//   register, before its first output byte is valid; while the emitter is busy
//   it waits in the input register.
// Throughput: one field item per cycle for printable bytes while text.ready
//   is high; an item that escapes to n bytes (n = 2 for letter escapes and
//   null, 4 for octal escapes) holds the emitter until its last byte leaves.
// Reset: clears both valid flags; no items are held afterward.
// Stall: when text.ready is low the current byte holds; the input register
//   keeps accepting until it is full, then field.ready drops.
`default_nettype none

module copy_text_field_escaper (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cte_field_if.sink  field,
    cte_text_if.source text
);
    import cte_pkg::*;

    cte_stage_t stage;
    logic       take;

    cte_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .field (field),
        .take  (take),
        .stage (stage)
    );

    cte_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .text  (text)
    );

endmodule

`default_nettype wire

@@ src/cte_checker.sv @@
// Port-level checks for copy_text_field_escaper, bound to the top level.
// Depends on cte_pkg.
`default_nettype none

module cte_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       text_valid,
    input wire logic       text_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run
);
    import cte_pkg::*;

    assert property (@(posedge clk) !rst_n |-> !text_valid)
        else $error("text valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(out_byte)
            && $stable(last_of_run))
        else $error("stalled text item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && !last_of_run |=> text_valid)
        else $error("escape run broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !last_of_run |->
            out_byte == CHAR_BACKSLASH
            || (out_byte >= CHAR_ZERO && out_byte <= CHAR_ZERO + 8'd7))
        else $error("unexpected byte inside escape run");

endmodule

bind copy_text_field_escaper cte_checker u_cte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_valid  (text.valid),
    .text_ready  (text.ready),
    .out_byte    (text.out_byte),
    .last_of_run (text.last_of_run)
);

`default_nettype wire

@@ sim/copy_text_field_escaper_checker.sv @@
// Checker for the copy text field escaper: predicts escaped text from accepted
// field items and compares every accepted text item in order.
// Depends on cte_pkg and the channel interfaces in cte_if.
module copy_text_field_escaper_checker (
    input  logic clk,
    input  logic rst_n,
    cte_field_if field,
    cte_text_if  text,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cte_pkg::*;

    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
    } text_beat_t;

    text_beat_t text_due[$];
    text_beat_t due;

    function automatic void push_beat(logic [7:0] b, logic last);
        text_beat_t beat;
        beat.out_byte    = b;
        beat.last_of_run = last;
        text_due.push_back(beat);
    endfunction

    function automatic void push_escape(logic kind, logic [7:0] c);
        logic [7:0] letter;
        case (c)
            CODE_BS:        letter = CHAR_LOWER_B;
            CODE_TAB:       letter = CHAR_LOWER_T;
            CODE_LF:        letter = CHAR_LOWER_N;
            CODE_VT:        letter = CHAR_LOWER_V;
            CODE_FF:        letter = CHAR_LOWER_F;
            CODE_CR:        letter = CHAR_LOWER_R;
            CHAR_BACKSLASH: letter = CHAR_BACKSLASH;
            default:        letter = 8'd0;
        endcase
        if (kind == KIND_NULL)
        begin
            push_beat(CHAR_BACKSLASH, 1'b0);
            push_beat(CHAR_UPPER_N, 1'b1);
        end
        else if (letter != 8'd0)
        begin
            push_beat(CHAR_BACKSLASH, 1'b0);
            push_beat(letter, 1'b1);
        end
        else if (c < CHAR_SPACE || c > CHAR_TILDE)
        begin
            push_beat(CHAR_BACKSLASH, 1'b0);
            push_beat(CHAR_ZERO + 8'(c[7:6]), 1'b0);
            push_beat(CHAR_ZERO + 8'(c[5:3]), 1'b0);
            push_beat(CHAR_ZERO + 8'(c[2:0]), 1'b1);
        end
        else
        begin
            push_beat(c, 1'b1);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (field.valid && field.ready)
                push_escape(field.kind, field.data_byte);
            if (text.valid && text.ready)
            begin
                if (text_due.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display("%0t: unexpected text item byte=%h last=%b",
                                 $realtime, text.out_byte, text.last_of_run);
                end
                else
                begin
                    due = text_due.pop_front();
                    if (text.out_byte !== due.out_byte
                        || text.last_of_run !== due.last_of_run)
                    begin
                        errors++;
                        if (errors <= SHOWN_ERRORS)
                            $display({"%0t: text mismatch expected byte=%h last=%b,",
                                      " got byte=%h last=%b"},
                                     $realtime, due.out_byte, due.last_of_run,
                                     text.out_byte, text.last_of_run);
                    end
                end
            end
        end
        pending = text_due.size();
    end

endmodule

@@ sim/copy_text_field_escaper_tb.sv @@
// Testbench top for the copy text field escaper: clock, reset, field stimulus
// and text back-pressure; checking is done by copy_text_field_escaper_checker.
// Depends on cte_pkg, cte_if, the escaper RTL and the checker.
module copy_text_field_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cte_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_FROM    = 165;
    localparam int STALL_AT     = 40;
    localparam int STALL_CYCLES = 120;
    localparam int DRAIN_CYCLES = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   items_sent = 0;
    bit   calm       = 1'b0;
    bit   stall_done = 1'b0;

    cte_field_if field_ch ();
    cte_text_if  text_ch ();

    copy_text_field_escaper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .field (field_ch),
        .text  (text_ch)
    );

    copy_text_field_escaper_checker escape_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .field   (field_ch),
        .text    (text_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #2 clk = ~clk;

    task automatic send_field(logic kind, logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            field_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        field_ch.valid     <= 1'b1;
        field_ch.kind      <= kind;
        field_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!field_ch.ready);
        items_sent++;
    endtask

    function automatic logic [8:0] random_field();
        logic [7:0] letters [7] = '{CODE_BS, CODE_TAB, CODE_LF, CODE_VT, CODE_FF, CODE_CR,
                                    CHAR_BACKSLASH};
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 9);
        b    = 8'($urandom_range(0, 255));
        if (pick == 0)
            return {KIND_NULL, b};
        else if (pick <= 2)
            return {KIND_DATA, letters[$urandom_range(0, 6)]};
        else if (pick <= 5)
            return {KIND_DATA, 8'($urandom_range(CHAR_SPACE, CHAR_TILDE))};
        return {KIND_DATA, b};
    endfunction

    initial
    begin
        logic [8:0] directed [$];
        logic [8:0] item;
        directed = '{
            {KIND_NULL, 8'h00}, {KIND_NULL, 8'hFF}, {KIND_DATA, 8'h00},
            {KIND_DATA, CODE_BS}, {KIND_DATA, CODE_TAB}, {KIND_DATA, CODE_LF},
            {KIND_DATA, CODE_VT}, {KIND_DATA, CODE_FF}, {KIND_DATA, CODE_CR},
            {KIND_DATA, CHAR_BACKSLASH}, {KIND_DATA, 8'h07}, {KIND_DATA, 8'h0E},
            {KIND_DATA, 8'h1F}, {KIND_DATA, CHAR_SPACE}, {KIND_DATA, CHAR_TILDE},
            {KIND_DATA, 8'h7F}, {KIND_DATA, 8'h80}, {KIND_DATA, 8'hFF},
            {KIND_DATA, 8'h41}, {KIND_DATA, 8'h5B}, {KIND_DATA, 8'h5D}
        };
        field_ch.valid     = 1'b0;
        field_ch.kind      = KIND_DATA;
        field_ch.data_byte = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_field(directed[i][8], directed[i][7:0]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == CALM_FROM)
                calm = 1'b1;
            item = random_field();
            send_field(item[8], item[7:0]);
        end
        field_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("copy_text_field_escaper_tb passed");
        else
            $display("copy_text_field_escaper_tb failed");
        $finish;
    end

    // hold off the text side once long enough to fill the block; until calm, also stall it at random
    initial
    begin
        text_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!stall_done && items_sent >= STALL_AT)
            begin
                text_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                text_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                text_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #500us;
        $display("copy_text_field_escaper_tb failed");
        $finish;
    end

endmodule
